@@ rtl/lgs_pkg.sv @@
// Shared types and constants for the life grid generation step block.
// No dependencies; imported by lgs_cell_rule and life_grid_generation_step.
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

   localparam int LGS_ROWS = 32;
   localparam int LGS_COLS = 32;

   // Command codes; code 3 has no name, writes nothing and returns a zero cell value
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_STEP  = 2'd2;

   // B3/S23 neighbour counts
   localparam logic [3:0] LGS_SURVIVE = 4'd2;
   localparam logic [3:0] LGS_BIRTH   = 4'd3;

   typedef struct packed {
      logic [1:0] command;
      logic [4:0] row;
      logic [4:0] col;
      logic       value;
   } lgs_req_type;

   typedef struct packed {
      logic [1:0] done_command;
      logic       cell_value;
   } lgs_rsp_type;

   // 3x3 neighbourhood; in each row bit 0 is the left column, bit 1 the centre
   typedef struct packed {
      logic [2:0] above;
      logic [2:0] middle;
      logic [2:0] below;
   } lgs_window_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_RESOLVE,
      ST_LOAD0,
      ST_LOAD1,
      ST_LOAD2,
      ST_SCAN,
      ST_ROW_END
   } lgs_state_type;

endpackage

`default_nettype wire

@@ rtl/lgs_grid_mem.sv @@
// Row-wide grid memory: one write port and one read port with registered data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module lgs_grid_mem #(
   parameter int ROWS = 32,
   parameter int COLS = 32
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [$clog2(ROWS)-1:0] wr_addr,
   input  wire logic [COLS-1:0]         wr_data,
   input  wire logic                    rd_en,
   input  wire logic [$clog2(ROWS)-1:0] rd_addr,
   output      logic [COLS-1:0]         rd_data
);

   logic [COLS-1:0] grid_mem [ROWS];
   logic [COLS-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= grid_mem[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

`default_nettype wire

@@ rtl/lgs_cell_rule.sv @@
// Neighbour counter and B3/S23 rule for one cell, shared across the whole sweep.
// Depends on lgs_pkg for the window type and the rule constants.
`timescale 1ns / 1ps
`default_nettype none

module lgs_cell_rule (
   input  wire lgs_pkg::lgs_window_type window,
   output      logic                    alive
);

   import lgs_pkg::*;

   logic [3:0] count;

   always_comb begin
      count = 4'(window.middle[0]) + 4'(window.middle[2]);
      for (int i = 0; i < 3; i++) begin
         count = count + 4'(window.above[i]) + 4'(window.below[i]);
      end
   end

   assign alive = (count == LGS_BIRTH) || (window.middle[1] && (count == LGS_SURVIVE));

endmodule

`default_nettype wire

@@ rtl/life_grid_generation_step.sv @@
// Life grid of ROWS x COLS one-bit cells (rule B3/S23, non-wrapping edges). After
// reset the grid memory is cleared one row per cycle with busy high. A cell write
// or read holds busy through the ACCESS and RESOLVE states (row read, then
// read-modify-write) and its result strobes on rsp_valid as the block returns to
// idle. In a generation step one shared rule unit evaluates one cell per cycle over
// a three-row window, with a ROW_END state per row to write the new row back
// through the single memory write port. Results are presented for one cycle only;
// the receiver cannot stall them.
`timescale 1ns / 1ps
`default_nettype none

module life_grid_generation_step #(
   parameter int ROWS = lgs_pkg::LGS_ROWS,
   parameter int COLS = lgs_pkg::LGS_COLS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire lgs_pkg::lgs_req_type req_item,
   output      logic                 rsp_valid,
   output      lgs_pkg::lgs_rsp_type rsp_item
);

   import lgs_pkg::*;

   localparam int RowW = $clog2(ROWS);
   localparam int ColW = $clog2(COLS);

   lgs_state_type   state_ff, state_in;
   lgs_req_type     req_ff, req_in;
   logic [RowW-1:0] row_cnt_ff, row_cnt_in;
   logic [ColW-1:0] col_cnt_ff, col_cnt_in;
   logic [COLS-1:0] prev_ff, prev_in;
   logic [COLS-1:0] cur_ff, cur_in;
   logic [COLS-1:0] nxt_ff, nxt_in;
   logic [COLS-1:0] new_row_ff, new_row_in;
   logic [2:0]      left_ff, left_in;
   logic            rsp_valid_ff, rsp_valid_in;
   lgs_rsp_type     rsp_ff, rsp_in;

   logic            wr_en, rd_en;
   logic [RowW-1:0] wr_addr, rd_addr;
   logic [COLS-1:0] wr_data, rd_data;

   logic            req_inside;
   logic [RowW-1:0] req_row_idx;
   logic [ColW-1:0] req_col_idx;
   logic            last_row, last_col, has_row2;
   logic            cell_bit;
   lgs_window_type  window;
   logic            rule_alive;

   lgs_grid_mem #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) u_grid_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   lgs_cell_rule u_cell_rule (
      .window(window),
      .alive (rule_alive)
   );

   assign req_inside  = (32'(req_ff.row) < ROWS) && (32'(req_ff.col) < COLS);
   assign req_row_idx = RowW'(req_ff.row);
   assign req_col_idx = ColW'(req_ff.col);
   assign last_row    = (row_cnt_ff == RowW'(ROWS - 1));
   assign last_col    = (col_cnt_ff == ColW'(COLS - 1));
   assign has_row2    = ((32'(row_cnt_ff) + 32'd2) < ROWS);

   // Rows rotate right once per column, so bit 0 is the centre and bit 1 the right
   always_comb begin
      window.above  = {(last_col ? 1'b0 : prev_ff[1]), prev_ff[0], left_ff[0]};
      window.middle = {(last_col ? 1'b0 : cur_ff[1]),  cur_ff[0],  left_ff[1]};
      window.below  = {(last_col ? 1'b0 : nxt_ff[1]),  nxt_ff[0],  left_ff[2]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_cnt_ff   <= row_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      col_cnt_ff <= col_cnt_in;
      prev_ff    <= prev_in;
      cur_ff     <= cur_in;
      nxt_ff     <= nxt_in;
      new_row_ff <= new_row_in;
      left_ff    <= left_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      row_cnt_in   = row_cnt_ff;
      col_cnt_in   = col_cnt_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      new_row_in   = new_row_ff;
      left_in      = left_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = row_cnt_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = row_cnt_ff;
      cell_bit     = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (last_row) begin
               row_cnt_in = '0;
               state_in   = ST_IDLE;
            end else begin
               row_cnt_in = row_cnt_ff + RowW'(1);
            end
         end

         ST_IDLE: begin
            if (start) begin
               req_in     = req_item;
               row_cnt_in = '0;
               state_in   = (req_item.command == CMD_STEP) ? ST_LOAD0 : ST_ACCESS;
            end
         end

         ST_ACCESS: begin
            rd_en    = 1'b1;
            rd_addr  = req_row_idx;
            state_in = ST_RESOLVE;
         end

         ST_RESOLVE: begin
            // Read-modify-write of the addressed row on a write; a read returns the cell
            wr_addr              = req_row_idx;
            wr_data              = rd_data;
            wr_data[req_col_idx] = req_ff.value;
            wr_en                = req_inside && (req_ff.command == CMD_WRITE);
            if (req_inside && (req_ff.command == CMD_WRITE)) begin
               cell_bit = req_ff.value;
            end else if (req_inside && (req_ff.command == CMD_READ)) begin
               cell_bit = rd_data[req_col_idx];
            end
            rsp_valid_in        = 1'b1;
            rsp_in.done_command = req_ff.command;
            rsp_in.cell_value   = cell_bit;
            state_in            = ST_IDLE;
         end

         ST_LOAD0: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = ST_LOAD1;
         end

         ST_LOAD1: begin
            rd_en    = 1'b1;
            rd_addr  = RowW'(1);
            prev_in  = '0;
            cur_in   = rd_data;
            state_in = ST_LOAD2;
         end

         ST_LOAD2: begin
            nxt_in     = rd_data;
            col_cnt_in = '0;
            left_in    = '0;
            state_in   = ST_SCAN;
         end

         ST_SCAN: begin
            // Prefetch the row below the window while the port is free
            rd_addr    = row_cnt_ff + RowW'(2);
            rd_en      = (col_cnt_ff == '0) && has_row2;
            new_row_in = {rule_alive, new_row_ff[COLS-1:1]};
            left_in    = {nxt_ff[0], cur_ff[0], prev_ff[0]};
            prev_in    = {prev_ff[0], prev_ff[COLS-1:1]};
            cur_in     = {cur_ff[0], cur_ff[COLS-1:1]};
            nxt_in     = {nxt_ff[0], nxt_ff[COLS-1:1]};
            if (last_col) begin
               state_in = ST_ROW_END;
            end else begin
               col_cnt_in = col_cnt_ff + ColW'(1);
            end
         end

         ST_ROW_END: begin
            // Old rows are held in the window, so write back in place
            wr_en      = 1'b1;
            wr_addr    = row_cnt_ff;
            wr_data    = new_row_ff;
            prev_in    = cur_ff;
            cur_in     = nxt_ff;
            nxt_in     = has_row2 ? rd_data : '0;
            left_in    = '0;
            col_cnt_in = '0;
            if (last_row) begin
               row_cnt_in          = '0;
               rsp_valid_in        = 1'b1;
               rsp_in.done_command = CMD_STEP;
               rsp_in.cell_value   = 1'b0;
               state_in            = ST_IDLE;
            end else begin
               row_cnt_in = row_cnt_ff + RowW'(1);
               state_in   = ST_SCAN;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_rsp_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result in the cycle after a transaction was accepted");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !wr_en)
      else $error("grid write while idle");

   a_rsp_echoes_command: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.done_command == req_ff.command))
      else $error("result does not echo the accepted command");

   a_step_cell_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.done_command == CMD_STEP)) |-> !rsp_item.cell_value)
      else $error("generation step returned a non-zero cell value");

endmodule

`default_nettype wire
